// ----- src/pct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the pausable countdown timer.
package pct_pkg;

	// Number of preset duration slots
	localparam int NumPresets = 6;

	// Field widths
	localparam int OpW      = 4;
	localparam int MsW      = 32;
	localparam int SelW     = 27;
	localparam int MinW     = 12;
	localparam int PidxW    = 3;
	localparam int PcountW  = 3;
	localparam int SecW     = 23;
	localparam int ModeW    = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	// Signed width of minutes_delta * 60000 (full 12-bit input range fits)
	localparam int DeltaW   = 28;

	localparam logic [SelW-1:0] MaxDurationMs = 27'd86400000;
	localparam logic [16:0]     MsPerMinute   = 17'd60000;
	localparam logic [9:0]      RoundUpMs     = 10'd999;

	// Ceiling seconds: ((ms + 999) >> 3) / 125 as a multiply by reciprocal.
	// 30-bit dividend, error term 28 stays under 2^(37-30), so exact.
	localparam int              DivPreShift = 3;
	localparam int              DivInW      = 30;
	localparam int              RecipW      = 31;
	localparam int              RecipShift  = 37;
	localparam logic [RecipW-1:0] RecipM    = 31'd1099511628;
	localparam int              ProdW       = DivInW + RecipW;

	localparam logic [0:5][SelW-1:0] PresetDefaults = {
		27'd60000, 27'd300000, 27'd600000, 27'd900000, 27'd1800000, 27'd3600000
	};
	localparam logic [MsW-1:0]     TimeoutDefault = 32'd30000;
	localparam logic [PcountW-1:0] PcountDefault  = 3'd6;

	// Timer mode, one-hot
	typedef enum logic [3:0] {
		MODE_IDLE     = 4'b0001,
		MODE_RUNNING  = 4'b0010,
		MODE_PAUSED   = 4'b0100,
		MODE_FINISHED = 4'b1000
	} mode_t;

	localparam logic [ModeW-1:0] ModeCodeIdle     = 2'd0;
	localparam logic [ModeW-1:0] ModeCodeRunning  = 2'd1;
	localparam logic [ModeW-1:0] ModeCodePaused   = 2'd2;
	localparam logic [ModeW-1:0] ModeCodeFinished = 2'd3;

	// Command codes
	typedef enum logic [OpW-1:0] {
		OP_TICK     = 4'd0,
		OP_SET      = 4'd1,
		OP_PRESET   = 4'd2,
		OP_START    = 4'd3,
		OP_PAUSE    = 4'd4,
		OP_RESUME   = 4'd5,
		OP_CANCEL   = 4'd6,
		OP_ADD_MIN  = 4'd7,
		OP_DISMISS  = 4'd8
	} op_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ALERT_TIMEOUT = 3'd0,
		CFG_PRESET_COUNT  = 3'd1,
		CFG_PRESET_0      = 3'd2
	} cfg_reg_t;

	// Configuration snapshot
	typedef struct packed {
		logic [MsW-1:0]                 alert_timeout_ms;
		logic [PcountW-1:0]             preset_count;
		logic [NumPresets-1:0][SelW-1:0] preset_ms;
	} cfg_t;

	// Registered input item
	typedef struct packed {
		logic [OpW-1:0]           opcode;
		logic [MsW-1:0]           duration_ms;
		logic signed [DeltaW-1:0] delta_ms;
		logic [PidxW-1:0]         preset_index;
	} cmd_t;

	// Timer state after one item plus per-item flags
	typedef struct packed {
		mode_t           mode;
		logic [MsW-1:0]  remaining;
		logic [MsW-1:0]  total;
		logic [SelW-1:0] selected;
		logic            alert;
		logic            finished_now;
		logic            accepted;
	} res_t;

	// Load enables for the seconds pipeline
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} pipe_ctl_t;

	// Result item
	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [MsW-1:0]   remaining_ms;
		logic [SecW-1:0]  remaining_seconds;
		logic [MsW-1:0]   total_ms;
		logic [SelW-1:0]  selected_ms;
		logic             alert_active;
		logic             finished_now;
		logic             seconds_changed;
		logic             accepted;
	} out_t;

	function automatic logic [ModeW-1:0] mode_code(input mode_t m);
		logic [ModeW-1:0] c;
		unique case (m)
			MODE_IDLE:     c = ModeCodeIdle;
			MODE_RUNNING:  c = ModeCodeRunning;
			MODE_PAUSED:   c = ModeCodePaused;
			MODE_FINISHED: c = ModeCodeFinished;
			default:       c = ModeCodeIdle;
		endcase
		return c;
	endfunction

endpackage

// ----- src/pct_ifs.sv -----
`timescale 1ns / 1ps
// Channel interfaces: command items, result items and configuration writes.
interface pct_cmd_if import pct_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OpW-1:0]          opcode;
	logic [MsW-1:0]          duration_ms;
	logic signed [MinW-1:0]  minutes_delta;
	logic [PidxW-1:0]        preset_index;

	modport source (output valid, opcode, duration_ms, minutes_delta, preset_index,
		input ready);
	modport sink (input valid, opcode, duration_ms, minutes_delta, preset_index,
		output ready);
endinterface

interface pct_rsp_if import pct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ModeW-1:0] mode;
	logic [MsW-1:0]   remaining_ms;
	logic [SecW-1:0]  remaining_seconds;
	logic [MsW-1:0]   total_ms;
	logic [SelW-1:0]  selected_ms;
	logic             alert_active;
	logic             finished_now;
	logic             seconds_changed;
	logic             accepted;

	modport source (output valid, mode, remaining_ms, remaining_seconds, total_ms,
		selected_ms, alert_active, finished_now, seconds_changed, accepted,
		input ready);
	modport sink (input valid, mode, remaining_ms, remaining_seconds, total_ms,
		selected_ms, alert_active, finished_now, seconds_changed, accepted,
		output ready);
endinterface

interface pct_cfg_if import pct_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pct_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: alert timeout, preset count and preset slots.
module pct_cfg_regs import pct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pct_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;
	logic wr;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign regs      = regs_q;

	// Store register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.alert_timeout_ms <= TimeoutDefault;
			regs_q.preset_count     <= PcountDefault;
			for (int i = 0; i < NumPresets; i++) begin
				regs_q.preset_ms[i] <= PresetDefaults[i];
			end
		end else if (wr) begin
			if (cfg.index == CFG_ALERT_TIMEOUT) begin
				regs_q.alert_timeout_ms <= cfg.data;
			end
			if (cfg.index == CFG_PRESET_COUNT) begin
				regs_q.preset_count <= cfg.data[PcountW-1:0];
			end
			for (int i = 0; i < NumPresets; i++) begin
				if (cfg.index == CFG_PRESET_0 + CfgIdxW'(i)) begin
					regs_q.preset_ms[i] <= cfg.data[SelW-1:0];
				end
			end
		end
	end

endmodule

// ----- src/pct_core.sv -----
`timescale 1ns / 1ps
// Timer state update: applies one item to the mode, counters and alert.
module pct_core import pct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  cmd_t item,
	input  logic upd,
	output res_t res
);

	mode_t           mode_q, mode_d;
	logic [MsW-1:0]  rem_q, rem_d;
	logic [MsW-1:0]  tot_q, tot_d;
	logic [SelW-1:0] sel_q, sel_d;
	logic            alert_q, alert_d;
	logic [MsW-1:0]  elapsed_q, elapsed_d;
	logic            fin_q, fin_d;
	logic            acc_q, acc_d;

	function automatic logic [MsW-1:0] sat_add(input logic [MsW-1:0] base,
		input logic signed [DeltaW-1:0] delta);
		logic signed [MsW+1:0] s;
		s = $signed({2'b00, base}) + $signed({{(MsW+2-DeltaW){delta[DeltaW-1]}}, delta});
		if (s[MsW+1]) begin
			return '0;
		end else if (s[MsW]) begin
			return '1;
		end
		return s[MsW-1:0];
	endfunction

	function automatic logic [SelW-1:0] clamp_ms(input logic [MsW-1:0] v);
		return (v > MsW'(MaxDurationMs)) ? MaxDurationMs : v[SelW-1:0];
	endfunction

	// Next state for the item in the input register
	always_comb begin
		logic [MsW-1:0]  rem_dec;
		logic [MsW-1:0]  el_inc;
		logic [SelW-1:0] preset_val;
		logic            preset_ok;
		logic            cancel;

		mode_d    = mode_q;
		rem_d     = rem_q;
		tot_d     = tot_q;
		sel_d     = sel_q;
		alert_d   = alert_q;
		elapsed_d = elapsed_q;
		fin_d     = 1'b0;
		acc_d     = 1'b1;
		cancel    = 1'b0;

		rem_dec = rem_q - MsW'(rem_q != '0);
		el_inc  = elapsed_q + MsW'(elapsed_q != '1);

		preset_val = '0;
		for (int i = 0; i < NumPresets; i++) begin
			if (item.preset_index == PidxW'(i)) begin
				preset_val = cfg.preset_ms[i];
			end
		end
		preset_ok = ({1'b0, item.preset_index} < {1'b0, cfg.preset_count})
			&& ({1'b0, item.preset_index} < (PidxW+1)'(NumPresets));

		unique case (op_t'(item.opcode))
			OP_TICK: begin
				if (mode_q == MODE_RUNNING) begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						mode_d    = MODE_FINISHED;
						alert_d   = 1'b1;
						elapsed_d = '0;
						fin_d     = 1'b1;
					end
				end else if (alert_q) begin
					// Alert times out on its own
					elapsed_d = el_inc;
					if (el_inc >= cfg.alert_timeout_ms) begin
						cancel = 1'b1;
					end
				end
			end
			OP_SET: begin
				sel_d = clamp_ms(item.duration_ms);
			end
			OP_PRESET: begin
				if (preset_ok) begin
					sel_d = clamp_ms(MsW'(preset_val));
				end else begin
					acc_d = 1'b0;
				end
			end
			OP_START: begin
				if (sel_q == '0) begin
					acc_d = 1'b0;
				end else begin
					alert_d   = 1'b0;
					elapsed_d = '0;
					tot_d     = MsW'(sel_q);
					rem_d     = MsW'(sel_q);
					mode_d    = MODE_RUNNING;
				end
			end
			OP_PAUSE: begin
				if (mode_q == MODE_RUNNING) begin
					mode_d = MODE_PAUSED;
				end else begin
					acc_d = 1'b0;
				end
			end
			OP_RESUME: begin
				if (mode_q == MODE_PAUSED && rem_q != '0) begin
					mode_d = MODE_RUNNING;
				end else begin
					acc_d = 1'b0;
				end
			end
			OP_CANCEL, OP_DISMISS: begin
				cancel = 1'b1;
			end
			OP_ADD_MIN: begin
				if (mode_q == MODE_RUNNING || mode_q == MODE_PAUSED) begin
					tot_d = sat_add(tot_q, item.delta_ms);
					rem_d = sat_add(rem_q, item.delta_ms);
				end else begin
					acc_d = 1'b0;
				end
			end
			default: begin
				acc_d = 1'b0;
			end
		endcase

		// Drop back to idle
		if (cancel) begin
			alert_d   = 1'b0;
			elapsed_d = '0;
			tot_d     = '0;
			rem_d     = '0;
			mode_d    = MODE_IDLE;
		end
	end

	// Commit state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			rem_q     <= '0;
			tot_q     <= '0;
			sel_q     <= '0;
			alert_q   <= 1'b0;
			elapsed_q <= '0;
			fin_q     <= 1'b0;
			acc_q     <= 1'b0;
		end else if (upd) begin
			mode_q    <= mode_d;
			rem_q     <= rem_d;
			tot_q     <= tot_d;
			sel_q     <= sel_d;
			alert_q   <= alert_d;
			elapsed_q <= elapsed_d;
			fin_q     <= fin_d;
			acc_q     <= acc_d;
		end
	end

	assign res.mode         = mode_q;
	assign res.remaining    = rem_q;
	assign res.total        = tot_q;
	assign res.selected     = sel_q;
	assign res.alert        = alert_q;
	assign res.finished_now = fin_q;
	assign res.accepted     = acc_q;

endmodule

// ----- src/pct_secs.sv -----
`timescale 1ns / 1ps
// Ceiling-seconds pipeline: round up, reciprocal multiply, change detect.
module pct_secs import pct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  res_t      res,
	output out_t      out
);

	res_t              res_s3, res_s4;
	logic [DivInW-1:0] x_s3;
	logic [ProdW-1:0]  prod_s4;
	logic [ProdW-1:0]  prod;
	logic [MsW:0]      rounded;
	logic [SecW-1:0]   secs;
	logic [SecW-1:0]   last_q;
	out_t              out_s5;

	assign rounded = {1'b0, res.remaining} + (MsW+1)'(RoundUpMs);
	assign prod    = ProdW'(x_s3) * ProdW'(RecipM);
	assign secs    = prod_s4[RecipShift +: SecW];

	// Round up and pre-divide by eight
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			res_s3 <= res;
			x_s3   <= rounded[DivPreShift +: DivInW];
		end
	end

	// Multiply by the reciprocal of 125
	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			res_s4  <= res_s3;
			prod_s4 <= prod;
		end
	end

	// Build the result item
	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			out_s5.mode              <= mode_code(res_s4.mode);
			out_s5.remaining_ms      <= res_s4.remaining;
			out_s5.remaining_seconds <= secs;
			out_s5.total_ms          <= res_s4.total;
			out_s5.selected_ms       <= res_s4.selected;
			out_s5.alert_active      <= res_s4.alert;
			out_s5.finished_now      <= res_s4.finished_now;
			out_s5.seconds_changed   <= (secs != last_q);
			out_s5.accepted          <= res_s4.accepted;
		end
	end

	// Track the last reported seconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctl.ld_s5) begin
			last_q <= secs;
		end
	end

	assign out = out_s5;

endmodule

// ----- src/pausable_countdown_timer.sv -----
`timescale 1ns / 1ps
// Top level: pausable countdown timer with preset slots and self-dismissing alert.
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    index, data (ready always high)
//   cmd      in   valid/ready    opcode, duration_ms, minutes_delta, preset_index
//   rsp      out  valid/ready    mode, remaining_ms, remaining_seconds, total_ms,
//                                selected_ms, alert_active, finished_now,
//                                seconds_changed, accepted
//
// One item per clock sustained while rsp.ready stays high; each result passes
// through five registers (input register, state update, round-up,
// reciprocal multiply, result register).
// The state update reads its own registered state, so back-to-back items see each other's state.
// Every stage holds while the next is full and cannot move on; the rsp register stalls on rsp.ready.
// arst_n clears the timer state, valid bits and last seconds, and sets the config registers to their defaults.
module pausable_countdown_timer import pct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pct_cfg_if.sink    cfg,
	pct_cmd_if.sink    cmd,
	pct_rsp_if.source  rsp
);

	cfg_t      regs;
	cmd_t      cmd_s1;
	res_t      res_s2;
	out_t      out_s5;
	pipe_ctl_t ctl;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic ld_s1, ld_s2;
	logic signed [DeltaW-1:0] delta_full;

	// Stage ready chain
	assign rdy_s5 = !v_s5 || rsp.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign ld_s1     = cmd.valid && rdy_s1;
	assign ld_s2     = v_s1 && rdy_s2;
	assign ctl.ld_s3 = v_s2 && rdy_s3;
	assign ctl.ld_s4 = v_s3 && rdy_s4;
	assign ctl.ld_s5 = v_s4 && rdy_s5;

	assign cmd.ready = rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= ld_s1 || (v_s1 && !ld_s2);
			v_s2 <= ld_s2 || (v_s2 && !ctl.ld_s3);
			v_s3 <= ctl.ld_s3 || (v_s3 && !ctl.ld_s4);
			v_s4 <= ctl.ld_s4 || (v_s4 && !ctl.ld_s5);
			v_s5 <= ctl.ld_s5 || (v_s5 && !rsp.ready);
		end
	end

	// Scale minutes to milliseconds on the way in
	assign delta_full = DeltaW'(cmd.minutes_delta) * $signed({1'b0, MsPerMinute});

	// Capture the input item
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1.opcode       <= cmd.opcode;
			cmd_s1.duration_ms  <= cmd.duration_ms;
			cmd_s1.delta_ms     <= delta_full;
			cmd_s1.preset_index <= cmd.preset_index;
		end
	end

	pct_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pct_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (regs),
		.item   (cmd_s1),
		.upd    (ld_s2),
		.res    (res_s2)
	);

	pct_secs u_secs (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.res    (res_s2),
		.out    (out_s5)
	);

	assign rsp.valid             = v_s5;
	assign rsp.mode              = out_s5.mode;
	assign rsp.remaining_ms      = out_s5.remaining_ms;
	assign rsp.remaining_seconds = out_s5.remaining_seconds;
	assign rsp.total_ms          = out_s5.total_ms;
	assign rsp.selected_ms       = out_s5.selected_ms;
	assign rsp.alert_active      = out_s5.alert_active;
	assign rsp.finished_now      = out_s5.finished_now;
	assign rsp.seconds_changed   = out_s5.seconds_changed;
	assign rsp.accepted          = out_s5.accepted;

	// An alert only exists while the timer sits in finished mode
	a_alert_finished: assert property (@(posedge clk) disable iff (!arst_n)
		res_s2.alert |-> res_s2.mode == MODE_FINISHED)
		else $error("alert raised outside finished mode");

	// The item that ends a run reports finished mode with the alert up
	a_finish_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.finished_now |-> rsp.mode == ModeCodeFinished && rsp.alert_active
			&& rsp.remaining_ms == '0)
		else $error("finish item without finished mode or alert");

	// Reported seconds are the ceiling of the remaining milliseconds
	a_ceil_secs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (34'(rsp.remaining_seconds) * 34'd1000 >= 34'(rsp.remaining_ms))
			&& (rsp.remaining_seconds == '0
				|| (34'(rsp.remaining_seconds) - 34'd1) * 34'd1000 < 34'(rsp.remaining_ms)))
		else $error("remaining_seconds is not the rounded-up quotient");

endmodule

// ----- tb/pausable_countdown_timer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the pausable countdown timer: directed and random command items.
module pausable_countdown_timer_test;
	import pct_pkg::*;

	localparam logic [OpW-1:0] OpFirstUnknown = 4'd9;
	localparam logic [OpW-1:0] OpLast         = 4'hF;
	localparam int             IdleMax        = 12;
	localparam int             DrainCycles    = 10;
	localparam longint         RunLimitNs     = 64'd20_000_000;

	logic clk;
	logic arst_n;

	pct_cfg_if cfg_ch ();
	pct_cmd_if cmd_ch ();
	pct_rsp_if rsp_ch ();

	pausable_countdown_timer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Predicted configuration
	logic [MsW-1:0]     cfg_timeout;
	logic [PcountW-1:0] cfg_count;
	logic [SelW-1:0]    cfg_slot [NumPresets];
	// Slot values for the next configuration pass
	logic [MsW-1:0]     slot_plan [NumPresets];

	// Predicted timer state
	logic [ModeW-1:0] tm_mode;
	logic [MsW-1:0]   tm_remaining;
	logic [MsW-1:0]   tm_total;
	logic [SelW-1:0]  tm_selected;
	logic             tm_alert;
	logic [MsW-1:0]   tm_elapsed;
	logic [SecW-1:0]  tm_last_secs;

	out_t timer_status_q [$];
	int   items_sent   = 0;
	int   statuses_seen = 0;
	int   mismatches   = 0;
	bit   idle_on      = 1'b1;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake hangs
	initial begin
		#(RunLimitNs);
		$display("Some tests failed");
		$finish;
	end

	function automatic void reset_model();
		cfg_timeout  = TimeoutDefault;
		cfg_count    = PcountDefault;
		for (int i = 0; i < NumPresets; i++) cfg_slot[i] = PresetDefaults[i];
		tm_mode      = ModeCodeIdle;
		tm_remaining = '0;
		tm_total     = '0;
		tm_selected  = '0;
		tm_alert     = 1'b0;
		tm_elapsed   = '0;
		tm_last_secs = '0;
	endfunction

	// Random noise for payload fields
	function automatic logic signed [MinW-1:0] rand_mins();
		return MinW'($urandom);
	endfunction

	function automatic logic [PidxW-1:0] rand_pidx();
		return PidxW'($urandom);
	endfunction

	function automatic logic [SelW-1:0] clamp_ms(input logic [MsW-1:0] v);
		return (v > MsW'(MaxDurationMs)) ? MaxDurationMs : v[SelW-1:0];
	endfunction

	function automatic logic [MsW-1:0] add_saturated(input logic [MsW-1:0] base,
			input longint delta);
		longint sum;
		sum = $signed({32'd0, base}) + delta;
		if (sum < 0) return '0;
		if (sum > 64'sh0_FFFF_FFFF) return '1;
		return sum[MsW-1:0];
	endfunction

	function automatic void clear_timer();
		tm_alert     = 1'b0;
		tm_elapsed   = '0;
		tm_total     = '0;
		tm_remaining = '0;
		tm_mode      = ModeCodeIdle;
	endfunction

	// Apply one command item to the predicted timer and return the status it reports
	function automatic out_t advance_timer(input logic [OpW-1:0] op, input logic [MsW-1:0] dur,
			input logic signed [MinW-1:0] mins, input logic [PidxW-1:0] pidx);
		out_t        st;
		longint      delta;
		logic [63:0] secs;
		st = '0;
		st.accepted = 1'b1;
		case (op)
			OP_TICK: begin
				if (tm_mode == ModeCodeRunning) begin
					if (tm_remaining != 0) tm_remaining = tm_remaining - MsW'(1);
					if (tm_remaining == 0) begin
						tm_mode = ModeCodeFinished;
						tm_alert = 1'b1;
						tm_elapsed = '0;
						st.finished_now = 1'b1;
					end
				end else if (tm_alert) begin
					if (tm_elapsed != '1) tm_elapsed = tm_elapsed + MsW'(1);
					if (tm_elapsed >= cfg_timeout) clear_timer();
				end
			end
			OP_SET: tm_selected = clamp_ms(dur);
			OP_PRESET: begin
				if (pidx < cfg_count && pidx < NumPresets)
					tm_selected = clamp_ms(MsW'(cfg_slot[pidx]));
				else
					st.accepted = 1'b0;
			end
			OP_START: begin
				if (tm_selected == 0) begin
					st.accepted = 1'b0;
				end else begin
					tm_alert = 1'b0;
					tm_elapsed = '0;
					tm_total = MsW'(tm_selected);
					tm_remaining = MsW'(tm_selected);
					tm_mode = ModeCodeRunning;
				end
			end
			OP_PAUSE: begin
				if (tm_mode == ModeCodeRunning) tm_mode = ModeCodePaused;
				else st.accepted = 1'b0;
			end
			OP_RESUME: begin
				if (tm_mode == ModeCodePaused && tm_remaining != 0) tm_mode = ModeCodeRunning;
				else st.accepted = 1'b0;
			end
			OP_CANCEL, OP_DISMISS: clear_timer();
			OP_ADD_MIN: begin
				if (tm_mode == ModeCodeRunning || tm_mode == ModeCodePaused) begin
					delta = longint'(mins) * longint'(MsPerMinute);
					tm_total = add_saturated(tm_total, delta);
					tm_remaining = add_saturated(tm_remaining, delta);
				end else begin
					st.accepted = 1'b0;
				end
			end
			default: st.accepted = 1'b0;
		endcase
		// Round remaining time up to whole seconds
		secs = (64'(tm_remaining) + 64'(RoundUpMs)) / 64'd1000;
		st.seconds_changed   = (secs[SecW-1:0] != tm_last_secs);
		tm_last_secs         = secs[SecW-1:0];
		st.mode              = tm_mode;
		st.remaining_ms      = tm_remaining;
		st.remaining_seconds = secs[SecW-1:0];
		st.total_ms          = tm_total;
		st.selected_ms       = tm_selected;
		st.alert_active      = tm_alert;
		return st;
	endfunction

	task automatic flag_status_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("status %0d: %s is %0d, expected %0d", statuses_seen, what, got, want);
		mismatches++;
	endtask

	// Compare one status item against the oldest prediction
	task automatic check_status();
		out_t want;
		statuses_seen++;
		if (timer_status_q.size() == 0) begin
			flag_status_mismatch("status with nothing pending", 1, 0);
		end else begin
			want = timer_status_q.pop_front();
			if (rsp_ch.mode !== want.mode)
				flag_status_mismatch("mode", rsp_ch.mode, want.mode);
			if (rsp_ch.remaining_ms !== want.remaining_ms)
				flag_status_mismatch("remaining_ms", rsp_ch.remaining_ms, want.remaining_ms);
			if (rsp_ch.remaining_seconds !== want.remaining_seconds)
				flag_status_mismatch("remaining_seconds", rsp_ch.remaining_seconds,
					want.remaining_seconds);
			if (rsp_ch.total_ms !== want.total_ms)
				flag_status_mismatch("total_ms", rsp_ch.total_ms, want.total_ms);
			if (rsp_ch.selected_ms !== want.selected_ms)
				flag_status_mismatch("selected_ms", rsp_ch.selected_ms, want.selected_ms);
			if (rsp_ch.alert_active !== want.alert_active)
				flag_status_mismatch("alert_active", rsp_ch.alert_active, want.alert_active);
			if (rsp_ch.finished_now !== want.finished_now)
				flag_status_mismatch("finished_now", rsp_ch.finished_now, want.finished_now);
			if (rsp_ch.seconds_changed !== want.seconds_changed)
				flag_status_mismatch("seconds_changed", rsp_ch.seconds_changed,
					want.seconds_changed);
			if (rsp_ch.accepted !== want.accepted)
				flag_status_mismatch("accepted", rsp_ch.accepted, want.accepted);
		end
	endtask

	// Check every status item taken at a clock edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_status();
	end

	// Drop ready in random bursts while idling is on
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, IdleMax)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Send one command item, leaving valid high after acceptance
	task automatic send_item(input logic [OpW-1:0] op, input logic [MsW-1:0] dur,
			input logic signed [MinW-1:0] mins, input logic [PidxW-1:0] pidx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, IdleMax)) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.opcode        <= op;
		cmd_ch.duration_ms   <= dur;
		cmd_ch.minutes_delta <= mins;
		cmd_ch.preset_index  <= pidx;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);
		timer_status_q.push_back(advance_timer(op, dur, mins, pidx));
		items_sent++;
	endtask

	// Command whose payload fields are ignored: fill them with noise
	task automatic send_op(input logic [OpW-1:0] op);
		send_item(op, $urandom, rand_mins(), rand_pidx());
	endtask

	// Hold the command channel idle until every status has come back
	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		while (timer_status_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		if (idx == CFG_ALERT_TIMEOUT)
			cfg_timeout = data;
		else if (idx == CFG_PRESET_COUNT)
			cfg_count = data[PcountW-1:0];
		else if (idx >= CFG_PRESET_0 && idx < CFG_PRESET_0 + NumPresets)
			cfg_slot[idx - CFG_PRESET_0] = data[SelW-1:0];
	endtask

	// Write every register once the block has gone quiet; slots come from slot_plan
	task automatic program_config(input logic [MsW-1:0] timeout, input logic [CfgDataW-1:0] count);
		wait_drain();
		write_reg(CFG_ALERT_TIMEOUT, timeout);
		write_reg(CFG_PRESET_COUNT, count);
		for (int i = 0; i < NumPresets; i++)
			write_reg(CfgIdxW'(CFG_PRESET_0 + i), slot_plan[i]);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Rejections, clamping, unknown opcodes, preset bounds, pause/resume and restart
	task automatic test_command_rules();
		send_op(OP_TICK);
		send_op(OP_START);
		send_op(OP_PAUSE);
		send_op(OP_RESUME);
		send_item(OP_ADD_MIN, $urandom, 12'sd1, rand_pidx());
		send_op(OpFirstUnknown);
		send_op(OpLast);
		send_item(OP_SET, '0, rand_mins(), rand_pidx());
		send_item(OP_SET, '1, rand_mins(), rand_pidx());
		send_item(OP_SET, MsW'(MaxDurationMs) + 1, rand_mins(), rand_pidx());
		for (int i = 0; i < 8; i++) send_item(OP_PRESET, $urandom, rand_mins(), PidxW'(i));
		send_item(OP_SET, 32'd2500, rand_mins(), rand_pidx());
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_PAUSE);
		send_op(OP_TICK);
		send_op(OP_RESUME);
		send_op(OP_START);
		send_op(OP_CANCEL);
		send_op(OP_DISMISS);
	endtask

	// Expiry, alert timeout, paused at zero and a running timer driven to zero
	task automatic test_expiry_and_alert();
		for (int i = 0; i < NumPresets; i++) slot_plan[i] = MsW'(PresetDefaults[i]);
		program_config(32'd3, 32'(PcountDefault));
		send_item(OP_SET, 32'd2, rand_mins(), rand_pidx());
		send_op(OP_START);
		repeat (7) send_op(OP_TICK);
		send_item(OP_SET, 32'd5, rand_mins(), rand_pidx());
		send_op(OP_START);
		send_op(OP_PAUSE);
		send_item(OP_ADD_MIN, $urandom, -12'sd1, rand_pidx());
		send_op(OP_RESUME);
		send_op(OP_TICK);
		send_item(OP_ADD_MIN, $urandom, 12'sd1, rand_pidx());
		send_op(OP_RESUME);
		send_item(OP_ADD_MIN, $urandom, -12'sd2048, rand_pidx());
		send_op(OP_TICK);
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_DISMISS);
	endtask

	// Drive total and remaining into the upper limit and back down
	task automatic test_saturation();
		send_item(OP_SET, MsW'(MaxDurationMs), rand_mins(), rand_pidx());
		send_op(OP_START);
		repeat (36) send_item(OP_ADD_MIN, $urandom, 12'sd2047, rand_pidx());
		send_op(OP_TICK);
		send_op(OP_PAUSE);
		send_item(OP_ADD_MIN, $urandom, 12'sd2047, rand_pidx());
		send_item(OP_ADD_MIN, $urandom, -12'sd2048, rand_pidx());
		send_item(OP_ADD_MIN, $urandom, 12'sd1440, rand_pidx());
		send_item(OP_ADD_MIN, $urandom, -12'sd1440, rand_pidx());
		send_op(OP_RESUME);
		send_op(OP_CANCEL);
	endtask

	// Preset count at both ends, zero and oversized slots, longest and zero timeout
	task automatic test_config_extremes();
		slot_plan[0] = '0;
		slot_plan[1] = '1;
		slot_plan[2] = MsW'(MaxDurationMs);
		slot_plan[3] = 32'd1000;
		slot_plan[4] = 32'd1001;
		slot_plan[5] = 32'd1;
		program_config('1, 32'd0);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd0);
		program_config('1, 32'd7);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd0);
		send_op(OP_START);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd1);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd2);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd6);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd7);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd5);
		send_op(OP_START);
		repeat (4) send_op(OP_TICK);
		send_op(OP_DISMISS);
		program_config('0, 32'd7);
		send_item(OP_PRESET, $urandom, rand_mins(), 3'd5);
		send_op(OP_START);
		repeat (3) send_op(OP_TICK);
	endtask

	// Mostly well-formed runs with random content, plus some noise items
	task automatic drive_timer_sessions(input int n_items);
		int                     stop_at;
		int                     steps;
		int                     pick;
		logic signed [MinW-1:0] m;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_item(OpW'($urandom_range(0, OpLast)), $urandom, rand_mins(), rand_pidx());
			end else begin
				// select a duration and start the run
				if (pick < 40)
					send_item(OP_SET, $urandom_range(1, 40), rand_mins(), rand_pidx());
				else if (pick < 55)
					send_item(OP_SET, $urandom_range(1001, 1030), rand_mins(), rand_pidx());
				else if (pick < 60)
					send_item(OP_SET, $urandom, rand_mins(), rand_pidx());
				else
					send_item(OP_PRESET, $urandom, rand_mins(), PidxW'($urandom_range(0, 7)));
				send_op(OP_START);
				// advance mostly by ticks, mixing in the other commands
				steps = $urandom_range(5, 60);
				for (int k = 0; k < steps; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 65) begin
						send_op(OP_TICK);
					end else if (pick < 71) begin
						send_op(OP_PAUSE);
					end else if (pick < 77) begin
						send_op(OP_RESUME);
					end else if (pick < 85) begin
						if ($urandom_range(0, 3) == 0) m = rand_mins();
						else if ($urandom_range(0, 3) == 0) m = 12'sd1;
						else m = -12'sd1;
						send_item(OP_ADD_MIN, $urandom, m, rand_pidx());
					end else if (pick < 89) begin
						send_op(OP_START);
					end else if (pick < 92) begin
						send_item(OP_SET, $urandom_range(0, 40), rand_mins(), rand_pidx());
					end else if (pick < 95) begin
						send_item(OP_PRESET, $urandom, rand_mins(),
							PidxW'($urandom_range(0, 7)));
					end else if (pick < 97) begin
						send_op(OP_CANCEL);
					end else begin
						send_op(OP_DISMISS);
					end
				end
			end
		end
	endtask

	// Random runs under several configurations; the last one with no idling
	task automatic test_random_phases();
		for (int i = 0; i < NumPresets; i++) slot_plan[i] = $urandom_range(1, 40);
		program_config($urandom_range(1, 20), $urandom_range(1, 6));
		drive_timer_sessions(250);

		slot_plan[0] = '0;
		slot_plan[1] = $urandom;
		program_config('0, 32'd7);
		drive_timer_sessions(250);

		for (int i = 0; i < NumPresets; i++) slot_plan[i] = $urandom_range(1, 1030);
		program_config('1, 32'(PcountDefault));
		drive_timer_sessions(250);

		program_config(32'd1, 32'd0);
		drive_timer_sessions(180);

		idle_on = 1'b0;
		for (int i = 0; i < NumPresets; i++) slot_plan[i] = $urandom_range(1, 40);
		program_config($urandom_range(2, 10), 32'(PcountDefault));
		drive_timer_sessions(180);
	endtask

	// Reset, run each test in turn, then report
	initial begin
		arst_n               <= 1'b0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.opcode        <= OP_TICK;
		cmd_ch.duration_ms   <= '0;
		cmd_ch.minutes_delta <= '0;
		cmd_ch.preset_index  <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= CFG_ALERT_TIMEOUT;
		cfg_ch.data          <= '0;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_command_rules();
		test_expiry_and_alert();
		test_saturation();
		test_config_extremes();
		test_random_phases();
		wait_drain();

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
